>>> rtl/core/mbrtu_pkg.sv
package mbrtu_pkg;

	// Request action codes
	localparam logic [1:0] ACT_POLL         = 2'd0;
	localparam logic [1:0] ACT_WRITE_SINGLE = 2'd1;
	localparam logic [1:0] ACT_WRITE_MULTI  = 2'd2;
	localparam logic [1:0] ACT_UNSUPPORTED  = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_FIRST    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_LAST     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLED  = 2'd3;
	localparam int unsigned CFG_DATA_W = 16;

	// Modbus function codes and fixed payload bytes
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
	localparam logic [7:0] MULTI_QTY_HI    = 8'h00;
	localparam logic [7:0] MULTI_QTY_LO    = 8'h01;
	localparam logic [7:0] MULTI_BYTE_CNT  = 8'h02;

	// CRC-16 (Modbus)
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Frame byte positions
	localparam int unsigned IDX_W = 4;
	localparam logic [IDX_W-1:0] SHORT_DATA_LEN = 4'd6;
	localparam logic [IDX_W-1:0] LONG_DATA_LEN  = 4'd9;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic       init;
		logic       upd;
		logic [7:0] data;
	} crc_ctl_t;

endpackage

>>> rtl/core/mbrtu_req_if.sv
interface mbrtu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] register_address;
	logic [15:0] register_value;

	modport source (output valid, action, register_address, register_value, input ready);
	modport sink (input valid, action, register_address, register_value, output ready);
endinterface

>>> rtl/core/mbrtu_rsp_if.sv
interface mbrtu_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, tx_byte, last_byte, input ready);
	modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

>>> rtl/core/mbrtu_cfg_if.sv
interface mbrtu_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mbrtu_pkg::CFG_IDX_W-1:0]   index;
	logic [mbrtu_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/mbrtu_crc.sv
module mbrtu_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  mbrtu_pkg::crc_ctl_t ctl,
	output logic [15:0]         crc
);

	logic [15:0] crc_q;
	logic [15:0] crc_nxt;

	// Fold one byte through the reflected polynomial, one bit per step
	always_comb begin
		crc_nxt = crc_q ^ {8'h00, ctl.data};
		for (int i = 0; i < 8; i++) begin
			if (crc_nxt[0]) begin
				crc_nxt = (crc_nxt >> 1) ^ mbrtu_pkg::CRC_POLY;
			end else begin
				crc_nxt = crc_nxt >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mbrtu_pkg::CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= mbrtu_pkg::CRC_INIT;
		end else if (ctl.upd) begin
			crc_q <= crc_nxt;
		end
	end

	assign crc = crc_q;

endmodule

>>> rtl/core/mbrtu_framer.sv
module mbrtu_framer (
	input  logic                 clk,
	input  logic                 arst_n,
	mbrtu_req_if.sink            req,
	mbrtu_rsp_if.source          rsp,
	input  logic [7:0]           slave_address,
	input  logic [15:0]          poll_first_register,
	input  logic [15:0]          poll_last_register,
	input  logic                 link_enabled,
	input  logic [15:0]          crc,
	output mbrtu_pkg::crc_ctl_t  crc_ctl
);

	mbrtu_pkg::state_t state_q, state_nxt;

	logic [mbrtu_pkg::IDX_W-1:0] idx_q;
	logic                        multi_q;
	logic [7:0]                  func_q;
	logic [15:0]                 w1_q;
	logic [15:0]                 w2_q;

	logic       rsp_valid_q;
	logic [7:0] rsp_byte_q;
	logic       rsp_last_q;

	logic                        accept;
	logic                        go;
	logic                        load;
	logic [7:0]                  cur_byte;
	logic [mbrtu_pkg::IDX_W-1:0] data_len;
	logic                        is_data;
	logic                        is_last;
	logic [7:0]                  func_nxt;

	assign req.ready = (state_q == mbrtu_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	// drop the request when the link is closed or the action is unsupported
	assign go        = accept && link_enabled && (req.action != mbrtu_pkg::ACT_UNSUPPORTED);

	assign data_len = multi_q ? mbrtu_pkg::LONG_DATA_LEN : mbrtu_pkg::SHORT_DATA_LEN;
	assign is_data  = idx_q < data_len;
	assign is_last  = idx_q == (data_len + mbrtu_pkg::IDX_W'(1));
	assign load     = (state_q == mbrtu_pkg::ST_SEND) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		case (req.action)
			mbrtu_pkg::ACT_POLL:         func_nxt = mbrtu_pkg::FC_READ_HOLDING;
			mbrtu_pkg::ACT_WRITE_SINGLE: func_nxt = mbrtu_pkg::FC_WRITE_SINGLE;
			default:                     func_nxt = mbrtu_pkg::FC_WRITE_MULTI;
		endcase
	end

	always_comb begin
		case (idx_q)
			4'd0:    cur_byte = slave_address;
			4'd1:    cur_byte = func_q;
			4'd2:    cur_byte = w1_q[15:8];
			4'd3:    cur_byte = w1_q[7:0];
			4'd4:    cur_byte = multi_q ? mbrtu_pkg::MULTI_QTY_HI : w2_q[15:8];
			4'd5:    cur_byte = multi_q ? mbrtu_pkg::MULTI_QTY_LO : w2_q[7:0];
			4'd6:    cur_byte = multi_q ? mbrtu_pkg::MULTI_BYTE_CNT : crc[7:0];
			4'd7:    cur_byte = multi_q ? w2_q[15:8] : crc[15:8];
			4'd8:    cur_byte = w2_q[7:0];
			4'd9:    cur_byte = crc[7:0];
			4'd10:   cur_byte = crc[15:8];
			default: cur_byte = 8'h00;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mbrtu_pkg::ST_IDLE: begin
				if (go) begin
					state_nxt = mbrtu_pkg::ST_SEND;
				end
			end
			mbrtu_pkg::ST_SEND: begin
				if (load && is_last) begin
					state_nxt = mbrtu_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mbrtu_pkg::ST_IDLE;
		endcase
	end

	assign crc_ctl.init = go;
	assign crc_ctl.upd  = load && is_data;
	assign crc_ctl.data = cur_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbrtu_pkg::ST_IDLE;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (go) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + mbrtu_pkg::IDX_W'(1);
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			multi_q <= req.action == mbrtu_pkg::ACT_WRITE_MULTI;
			func_q  <= func_nxt;
			if (req.action == mbrtu_pkg::ACT_POLL) begin
				w1_q <= poll_first_register;
				w2_q <= poll_last_register - poll_first_register + 16'd1;
			end else begin
				w1_q <= req.register_address;
				w2_q <= req.register_value;
			end
		end
		if (load) begin
			rsp_byte_q <= cur_byte;
			rsp_last_q <= is_last;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.tx_byte   = rsp_byte_q;
	assign rsp.last_byte = rsp_last_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbrtu_pkg::ST_SEND) |-> (idx_q <= data_len + mbrtu_pkg::IDX_W'(1)))
		else $error("frame index ran past the CRC high byte");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> (state_q == mbrtu_pkg::ST_IDLE && rsp_last_q))
		else $error("frame did not close after its last byte");

	a_crc_seed: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (crc == mbrtu_pkg::CRC_INIT && idx_q == '0))
		else $error("CRC not seeded at frame start");

endmodule

>>> rtl/core/modbus_rtu_request_encoder.sv
// A frame request enters the send state, which then registers the first frame byte.
// Throughput: one byte per cycle while the sink takes them; 8 bytes for poll and
//   write-single, 11 for write-multiple; no new request is taken until a frame ends.
// The bytewise CRC unit, shared by every data byte, sets the pace of one byte a cycle.
// Dropped requests (link closed, unsupported action) leave the block idle and ready.
// Reset (arst_n low, asynchronous) clears the sequencer and loads register defaults.
module modbus_rtu_request_encoder (
	input  logic        clk,
	input  logic        arst_n,
	mbrtu_req_if.sink   req,
	mbrtu_rsp_if.source rsp,
	mbrtu_cfg_if.sink   cfg
);

	// Configuration registers
	logic [7:0]  slave_address_q;
	logic [15:0] poll_first_q;
	logic [15:0] poll_last_q;
	logic        link_enabled_q;

	mbrtu_pkg::crc_ctl_t crc_ctl;
	logic [15:0]         crc;

	// Take every configuration transaction at once; a write lands whatever the
	// sequencer is doing, so the host writes only while no frame is in flight
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'h01;
			poll_first_q    <= 16'h0000;
			poll_last_q     <= 16'h0000;
			link_enabled_q  <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				mbrtu_pkg::REG_SLAVE_ADDRESS: slave_address_q <= cfg.data[7:0];
				mbrtu_pkg::REG_POLL_FIRST:    poll_first_q    <= cfg.data;
				mbrtu_pkg::REG_POLL_LAST:     poll_last_q     <= cfg.data;
				mbrtu_pkg::REG_LINK_ENABLED:  link_enabled_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: walk the frame bytes, feed each data byte to the CRC unit,
	// then append CRC low and high bytes
	mbrtu_framer u_framer (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req                 (req),
		.rsp                 (rsp),
		.slave_address       (slave_address_q),
		.poll_first_register (poll_first_q),
		.poll_last_register  (poll_last_q),
		.link_enabled        (link_enabled_q),
		.crc                 (crc),
		.crc_ctl             (crc_ctl)
	);

	// Shared CRC-16 unit: seed at frame start, advance one byte per data-byte load
	mbrtu_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

endmodule

>>> test/tb_modbus_rtu_request_encoder.sv
module tb_modbus_rtu_request_encoder;
	import mbrtu_pkg::*;

	// Hard stop for a hung handshake; far above the slowest legal run.
	localparam int unsigned CYCLE_LIMIT = 500000;
	// Cycles to let a dropped request drain before touching the registers.
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned LONG_HOLD_CYCLES = 120;
	localparam int unsigned MAX_PRINTED = 100;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic clk;
	logic arst_n;

	mbrtu_req_if req_ch();
	mbrtu_rsp_if rsp_ch();
	mbrtu_cfg_if cfg_ch();

	modbus_rtu_request_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the register file, updated on each accepted write transaction.
	logic [7:0]  shadow_slave;
	logic [15:0] shadow_poll_first;
	logic [15:0] shadow_poll_last;
	logic        shadow_link_on;

	// Frame bytes still owed by the block, oldest first.
	frame_byte_t owed_bytes[$];
	frame_byte_t oldest_owed;

	int unsigned cycle_count;
	int unsigned mismatch_count;
	bit          sender_idles;
	bit          receiver_idles;
	int unsigned hold_off_request;

	always #5 clk = ~clk;

	// Abort on a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// One bytewise step of the Modbus CRC-16 (reflected polynomial).
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		return acc;
	endfunction

	// Build the request frame for one accepted transaction and queue its bytes.
	function automatic void queue_request_frame(input logic [1:0] action,
			input logic [15:0] address, input logic [15:0] value);
		logic [7:0]  frame [0:10];
		logic [15:0] count;
		logic [15:0] crc;
		int unsigned len;
		frame_byte_t entry;
		if (!shadow_link_on)
			return;
		count = shadow_poll_last - shadow_poll_first + 16'd1;
		frame[0] = shadow_slave;
		case (action)
			ACT_POLL: begin
				frame[1] = FC_READ_HOLDING;
				frame[2] = shadow_poll_first[15:8];
				frame[3] = shadow_poll_first[7:0];
				frame[4] = count[15:8];
				frame[5] = count[7:0];
				len = 6;
			end
			ACT_WRITE_SINGLE: begin
				frame[1] = FC_WRITE_SINGLE;
				frame[2] = address[15:8];
				frame[3] = address[7:0];
				frame[4] = value[15:8];
				frame[5] = value[7:0];
				len = 6;
			end
			ACT_WRITE_MULTI: begin
				frame[1] = FC_WRITE_MULTI;
				frame[2] = address[15:8];
				frame[3] = address[7:0];
				frame[4] = MULTI_QTY_HI;
				frame[5] = MULTI_QTY_LO;
				frame[6] = MULTI_BYTE_CNT;
				frame[7] = value[15:8];
				frame[8] = value[7:0];
				len = 9;
			end
			default: return;
		endcase
		crc = CRC_INIT;
		for (int i = 0; i < len; i++)
			crc = crc16_step(crc, frame[i]);
		// CRC goes out low byte first
		frame[len] = crc[7:0];
		frame[len + 1] = crc[15:8];
		len += 2;
		for (int i = 0; i < len; i++) begin
			entry.data = frame[i];
			entry.last = (i == len - 1);
			owed_bytes.push_back(entry);
		end
	endfunction

	// Offer one request; valid stays high on return so a zero gap chains transactions.
	task automatic send_request(input logic [1:0] action, input logic [15:0] address,
			input logic [15:0] value);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.action           <= action;
		req_ch.register_address <= address;
		req_ch.register_value   <= value;
		do @(posedge clk); while (!req_ch.ready);
		queue_request_frame(action, address, value);
	endtask

	// Write one register; valid always goes low between two writes before it is raised again.
	task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [15:0] data);
		int unsigned gap;
		gap = $urandom_range(0, 7);
		repeat (gap + 1) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (index)
			REG_SLAVE_ADDRESS: shadow_slave      = data[7:0];
			REG_POLL_FIRST:    shadow_poll_first = data;
			REG_POLL_LAST:     shadow_poll_last  = data;
			REG_LINK_ENABLED:  shadow_link_on    = data[0];
			default: ;
		endcase
	endtask

	// Drop valid, wait out every owed byte, then let a dropped request drain.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (owed_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] slave_word, input logic [15:0] first,
			input logic [15:0] last, input logic [15:0] link_word);
		wait_idle();
		write_register(REG_SLAVE_ADDRESS, slave_word);
		write_register(REG_POLL_FIRST, first);
		write_register(REG_POLL_LAST, last);
		write_register(REG_LINK_ENABLED, link_word);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Link closed out of reset: every action is dropped. Then open the link
	// alone and poll with the reset defaults (slave 1, range 0..0).
	task automatic test_reset_state();
		send_request(ACT_POLL, 16'h1234, 16'h5678);
		send_request(ACT_WRITE_SINGLE, 16'hFFFF, 16'hFFFF);
		send_request(ACT_WRITE_MULTI, 16'h0000, 16'h0000);
		send_request(ACT_UNSUPPORTED, 16'hA5A5, 16'h5A5A);
		wait_idle();
		write_register(REG_LINK_ENABLED, 16'h0001);
		send_request(ACT_POLL, 16'h0000, 16'h0000);
	endtask

	// Every function code with the field extremes, plus unsupported with the link open.
	task automatic test_function_codes();
		apply_settings(16'h00FF, 16'hFFFF, 16'hFFFF, 16'h0001);
		send_request(ACT_POLL, 16'h0000, 16'h0000);
		send_request(ACT_WRITE_SINGLE, 16'hFFFF, 16'hFFFF);
		send_request(ACT_WRITE_MULTI, 16'hFFFF, 16'hFFFF);
		send_request(ACT_UNSUPPORTED, 16'hFFFF, 16'hFFFF);
		apply_settings(16'hFF00, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_request(ACT_POLL, 16'hFFFF, 16'hFFFF);
		send_request(ACT_WRITE_SINGLE, 16'h0000, 16'h0000);
		send_request(ACT_WRITE_MULTI, 16'h0000, 16'h0000);
		send_request(ACT_WRITE_SINGLE, 16'hFF00, 16'h00FF);
		send_request(ACT_WRITE_MULTI, 16'h00FF, 16'hFF00);
	endtask

	// Poll counts that wrap: last one below first gives zero, a range from FFFF to 0 wraps past 0; then a plain range.
	task automatic test_reversed_range();
		apply_settings(16'h00A5, 16'h1234, 16'h1233, 16'h0001);
		send_request(ACT_POLL, 16'h0000, 16'h0000);
		apply_settings(16'h005A, 16'hFFFF, 16'h0000, 16'h0001);
		send_request(ACT_POLL, 16'h0000, 16'h0000);
		apply_settings(16'h0011, 16'h0100, 16'h017F, 16'h0001);
		send_request(ACT_POLL, 16'h0000, 16'h0000);
	endtask

	// Closed link with junk in the upper data bits: only bit 0 counts.
	task automatic test_link_closed();
		apply_settings(16'hC33C, 16'h0010, 16'h0020, 16'hFFFE);
		send_request(ACT_POLL, 16'h0001, 16'h0002);
		send_request(ACT_WRITE_SINGLE, 16'h0003, 16'h0004);
		send_request(ACT_WRITE_MULTI, 16'h0005, 16'h0006);
		send_request(ACT_UNSUPPORTED, 16'h0007, 16'h0008);
	endtask

	// Park the sink for a long stretch while requests keep coming back to back,
	// so the encoder fills and holds off its request side.
	task automatic test_backpressure();
		apply_settings(16'h0042, 16'h2000, 16'h2007, 16'h0001);
		sender_idles     = 1'b0;
		hold_off_request = LONG_HOLD_CYCLES;
		for (int i = 0; i < 10; i++)
			send_request((i % 3 == 0) ? ACT_WRITE_MULTI : ((i % 3 == 1) ? ACT_POLL :
				ACT_WRITE_SINGLE), pick_word(), pick_word());
		wait_idle();
		sender_idles = 1'b1;
	endtask

	// One random phase: fresh settings, then a stream of mostly real requests.
	task automatic run_random_phase(input int unsigned items, input bit link_on,
			input bit idles);
		logic [15:0] first;
		logic [15:0] last;
		logic [1:0]  action;
		int unsigned pick;
		first = pick_word();
		case ($urandom_range(0, 5))
			0: last = first - 16'd1;
			1: last = pick_word();
			default: last = first + 16'($urandom_range(0, 124));
		endcase
		apply_settings(16'($urandom_range(0, 16'hFFFF)), first, last,
			{15'($urandom_range(0, 16'h7FFF)), link_on});
		sender_idles   = idles;
		receiver_idles = idles;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				action = ACT_UNSUPPORTED;
			else
				action = 2'(pick % 3);
			send_request(action, pick_word(), pick_word());
		end
		wait_idle();
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	task automatic test_random_traffic();
		// first phase runs with no idling on either side
		run_random_phase(56, 1'b1, 1'b0);
		run_random_phase(56, 1'b1, 1'b1);
		run_random_phase(56, 1'b1, 1'b1);
		run_random_phase(12, 1'b0, 1'b1);
		run_random_phase(56, 1'b1, 1'b1);
		run_random_phase(56, 1'b1, ($urandom_range(0, 1) == 1));
		run_random_phase(56, 1'b1, 1'b1);
	endtask

	// Sink side: random stall per byte, or a long hold when one is requested.
	initial begin
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = receiver_idles ? $urandom_range(0, 7) : 0;
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid && hold_off_request == 0)
				@(posedge clk);
			if (hold_off_request != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold_off_request) @(posedge clk);
				hold_off_request = 0;
			end
		end
	end

	// Compare each accepted byte with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b",
					rsp_ch.tx_byte, rsp_ch.last_byte));
			end else begin
				oldest_owed = owed_bytes.pop_front();
				if (rsp_ch.tx_byte !== oldest_owed.data)
					report_mismatch($sformatf("tx_byte %02h, want %02h",
						rsp_ch.tx_byte, oldest_owed.data));
				if (rsp_ch.last_byte !== oldest_owed.last)
					report_mismatch($sformatf("last_byte %0b, want %0b on byte %02h",
						rsp_ch.last_byte, oldest_owed.last, oldest_owed.data));
			end
		end
	end

	initial begin
		clk                     = 1'b0;
		arst_n                  = 1'b0;
		cycle_count             = 0;
		mismatch_count          = 0;
		sender_idles            = 1'b1;
		receiver_idles          = 1'b1;
		hold_off_request        = 0;
		req_ch.valid            = 1'b0;
		req_ch.action           = ACT_POLL;
		req_ch.register_address = 16'h0000;
		req_ch.register_value   = 16'h0000;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = REG_SLAVE_ADDRESS;
		cfg_ch.data             = 16'h0000;
		// register defaults as they come out of reset
		shadow_slave            = 8'h01;
		shadow_poll_first       = 16'h0000;
		shadow_poll_last        = 16'h0000;
		shadow_link_on          = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_function_codes();
		test_reversed_range();
		test_link_closed();
		test_backpressure();
		test_random_traffic();

		// drain and give the block time to show stray bytes
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> modbus_rtu_request_encoder.f
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_req_if.sv
rtl/core/mbrtu_rsp_if.sv
rtl/core/mbrtu_cfg_if.sv
rtl/core/mbrtu_crc.sv
rtl/core/mbrtu_framer.sv
rtl/core/modbus_rtu_request_encoder.sv
test/tb_modbus_rtu_request_encoder.sv
